// File: hdl/tlbsd_pkg.sv
// ----------------------------------------------------------------------------
// tlbsd_pkg: shared types and codes of the shootdown mailbox table
// Result status codes, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package tlbsd_pkg;

  localparam int ADDR_W   = 48;
  localparam int MASK_W   = 32;
  localparam int CPU_W    = 5;
  localparam int SLOT_W   = 6;
  localparam int STAT_W   = 3;
  localparam int CFG_IX_W = 2;

  typedef logic [STAT_W-1:0]   status_t;
  typedef logic [CFG_IX_W-1:0] cfg_idx_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [MASK_W-1:0]   mask_t;
  typedef logic [CPU_W-1:0]    cpu_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  // Result status codes
  localparam status_t ST_POSTED  = 3'd0;
  localparam status_t ST_SKIPPED = 3'd1;
  localparam status_t ST_FULL    = 3'd2;
  localparam status_t ST_INVAL   = 3'd3;
  localparam status_t ST_NONE    = 3'd4;

  // Request types
  localparam logic REQ_POST    = 1'b0;
  localparam logic REQ_SERVICE = 1'b1;

  // Configuration register indexes
  localparam cfg_idx_t CFG_ONLINE_MASK  = 2'd0;
  localparam cfg_idx_t CFG_APIC_PRESENT = 2'd1;
  localparam cfg_idx_t CFG_KERNEL_BASE  = 2'd2;

  // Reset values of the configuration registers
  localparam mask_t ONLINE_RST = 32'h0000_0001;
  localparam addr_t KBASE_RST  = 48'h8000_0000_0000;

endpackage

// File: hdl/tlb_shootdown_mailbox_table.sv
// ----------------------------------------------------------------------------
// tlb_shootdown_mailbox_table: TLB shootdown mailbox slots
// Posts page invalidations into free slots and lets each processor drain the
// addresses still pending for it, one slot per step of a small sequencer.
// ----------------------------------------------------------------------------
//
//   channel | ports                         | moves
//   --------+-------------------------------+-------------------------------
//   cfg     | cfg_we, cfg_index, cfg_wdata  | register write, no handshake
//   in      | in_valid / in_ready           | one post or service request
//   out     | out_valid / out_ready         | one result (one or more per service)
//
// Steps: a skipped post visits no slot. A post scans from slot 0 to the first
// free one and claims it, or over all SLOTS slots on a full table. A service
// walks all SLOTS slots: an unused slot is passed over, a used one is read
// from memory, then checked and written back; then the final result is handed
// over. The slots are visited one at a time through the slot memories.
// Reset clears the per-slot used bits and the control and configuration
// registers; the slot memories need no clearing pass. A stalled result output
// holds the sequencer only when it has another result to hand over; in_ready is low while busy.
// ----------------------------------------------------------------------------
module tlb_shootdown_mailbox_table #(
  parameter int SLOTS = 64,
  parameter int CPUS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  tlbsd_pkg::cfg_idx_t cfg_index,
  input  tlbsd_pkg::addr_t    cfg_wdata,
  // requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  tlbsd_pkg::cpu_t     in_cpu_id,
  input  tlbsd_pkg::addr_t    in_vaddr,
  input  tlbsd_pkg::mask_t    in_other_space_mask,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output tlbsd_pkg::status_t  out_status,
  output tlbsd_pkg::slot_t    out_slot,
  output tlbsd_pkg::addr_t    out_inv_addr,
  output logic                out_send_ipi,
  output logic                out_last
);
  import tlbsd_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;  // work out post targets
  localparam logic [2:0] S_PSCAN = 3'd2;  // look for a free slot
  localparam logic [2:0] S_SSCAN = 3'd3;  // service: visit a slot
  localparam logic [2:0] S_SCHK  = 3'd4;  // service: check read data, write back
  localparam logic [2:0] S_SEND  = 3'd5;  // hand over the final result

  // configuration registers
  mask_t online_mask_r;
  logic  apic_present_r;
  addr_t kernel_base_r;

  // slot storage: masks and addresses in memories, used bits in flops
  logic [CPUS-1:0] pend_mem [SLOTS];
  addr_t           addr_mem [SLOTS];
  logic [SLOTS-1:0] used_r;
  logic [CPUS-1:0] rd_pend_r;
  addr_t           rd_addr_r;

  // sequencer
  logic [2:0]      state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;

  // latched request
  logic [CPUS-1:0] me_r;
  logic [CPUS-1:0] other_r;
  addr_t           vaddr_r;
  logic [CPUS-1:0] targets_r, targets_nxt;

  // result waiting for its successor (decides the last flag)
  logic    res_v_r, res_v_nxt;
  status_t res_status_r, res_status_nxt;
  slot_t   res_slot_r, res_slot_nxt;
  addr_t   res_addr_r, res_addr_nxt;
  logic    res_ipi_r, res_ipi_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  slot_t   out_slot_r, out_slot_nxt;
  addr_t   out_addr_r, out_addr_nxt;
  logic    out_ipi_r, out_ipi_nxt;
  logic    out_last_r, out_last_nxt;

  // write controls
  logic            pend_we;
  logic [CPUS-1:0] pend_wd;
  logic            addr_we;
  logic            used_we;
  logic            used_wd;

  // combinational helpers
  logic            in_acc;
  logic            out_free;
  logic [CPUS-1:0] me_in;
  logic [CPUS-1:0] online;
  logic            multi_online;
  logic            is_user;
  logic [CPUS-1:0] tgt;
  logic [CPUS-1:0] cleared;
  logic            hit;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // a processor at or above CPUS has no bit
  assign me_in = ({1'b0, in_cpu_id} < 6'(CPUS)) ? (CPUS'(1) << in_cpu_id) : '0;

  assign online       = online_mask_r[CPUS-1:0];
  assign multi_online = |(online & (online - CPUS'(1)));
  assign is_user      = vaddr_r < kernel_base_r;
  assign tgt          = online & ~me_r & (is_user ? ~other_r : '1);

  assign cleared = rd_pend_r & ~me_r;
  assign hit     = |(rd_pend_r & me_r);

  // configuration writes; out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_mask_r  <= ONLINE_RST;
      apic_present_r <= 1'b0;
      kernel_base_r  <= KBASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONLINE_MASK:  online_mask_r  <= cfg_wdata[MASK_W-1:0];
        CFG_APIC_PRESENT: apic_present_r <= cfg_wdata[0];
        CFG_KERNEL_BASE:  kernel_base_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer and result staging
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    targets_nxt    = targets_r;
    res_v_nxt      = res_v_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_addr_nxt   = res_addr_r;
    res_ipi_nxt    = res_ipi_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_addr_nxt   = out_addr_r;
    out_ipi_nxt    = out_ipi_r;
    out_last_nxt   = out_last_r;
    pend_we        = 1'b0;
    pend_wd        = cleared;
    addr_we        = 1'b0;
    used_we        = 1'b0;
    used_wd        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt   = '0;
          res_v_nxt = 1'b0;
          state_nxt = (in_req_type == REQ_SERVICE) ? S_SSCAN : S_EVAL;
        end
      end

      S_EVAL: begin
        targets_nxt = tgt;
        if (!apic_present_r || !multi_online || (tgt == '0)) begin
          res_v_nxt      = 1'b1;
          res_status_nxt = ST_SKIPPED;
          res_slot_nxt   = '0;
          res_addr_nxt   = '0;
          res_ipi_nxt    = 1'b0;
          state_nxt      = S_SEND;
        end else begin
          state_nxt = S_PSCAN;
        end
      end

      S_PSCAN: begin
        if (!used_r[idx_r]) begin
          // claim the lowest free slot
          pend_we        = 1'b1;
          pend_wd        = targets_r;
          addr_we        = 1'b1;
          used_we        = 1'b1;
          used_wd        = 1'b1;
          res_v_nxt      = 1'b1;
          res_status_nxt = ST_POSTED;
          res_slot_nxt   = SLOT_W'(idx_r);
          res_addr_nxt   = '0;
          res_ipi_nxt    = 1'b1;
          state_nxt      = S_SEND;
        end else if (idx_r == IDX_LAST) begin
          res_v_nxt      = 1'b1;
          res_status_nxt = ST_FULL;
          res_slot_nxt   = '0;
          res_addr_nxt   = '0;
          res_ipi_nxt    = 1'b0;
          state_nxt      = S_SEND;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_SSCAN: begin
        // a used slot is read this cycle and checked in the next
        if (used_r[idx_r]) begin
          state_nxt = S_SCHK;
        end else if (idx_r == IDX_LAST) begin
          state_nxt = S_SEND;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_SCHK: begin
        if (!hit || !res_v_r || out_free) begin
          if (hit) begin
            pend_we = 1'b1;
            used_we = 1'b1;
            used_wd = |cleared;
            // the staged hit now has a successor, so it is not the last one
            if (res_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = res_status_r;
              out_slot_nxt   = res_slot_r;
              out_addr_nxt   = res_addr_r;
              out_ipi_nxt    = res_ipi_r;
              out_last_nxt   = 1'b0;
            end
            res_v_nxt      = 1'b1;
            res_status_nxt = ST_INVAL;
            res_slot_nxt   = SLOT_W'(idx_r);
            res_addr_nxt   = rd_addr_r;
            res_ipi_nxt    = 1'b0;
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = S_SEND;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_SSCAN;
          end
        end
      end

      S_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (res_v_r) begin
            out_status_nxt = res_status_r;
            out_slot_nxt   = res_slot_r;
            out_addr_nxt   = res_addr_r;
            out_ipi_nxt    = res_ipi_r;
          end else begin
            // service found nothing for this processor
            out_status_nxt = ST_NONE;
            out_slot_nxt   = '0;
            out_addr_nxt   = '0;
            out_ipi_nxt    = 1'b0;
          end
          res_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      res_v_r     <= res_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (used_we) begin
        used_r[idx_r] <= used_wd;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    targets_r    <= targets_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_addr_r   <= res_addr_nxt;
    res_ipi_r    <= res_ipi_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ipi_r    <= out_ipi_nxt;
    out_last_r   <= out_last_nxt;
    if (in_acc) begin
      me_r    <= me_in;
      other_r <= in_other_space_mask[CPUS-1:0];
      vaddr_r <= in_vaddr;
    end
  end

  // slot memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[idx_r] <= pend_wd;
    end
    if (addr_we) begin
      addr_mem[idx_r] <= vaddr_r;
    end
    rd_pend_r <= pend_mem[idx_r];
    rd_addr_r <= addr_mem[idx_r];
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot     = out_slot_r;
  assign out_inv_addr = out_addr_r;
  assign out_send_ipi = out_ipi_r;
  assign out_last     = out_last_r;

endmodule

// File: hdl/tlbsd_chk.sv
// ----------------------------------------------------------------------------
// tlbsd_chk: port checker for the shootdown mailbox table
// Watches the request and result ports and flags malformed results and a ready that stays high after a request.
// ----------------------------------------------------------------------------
module tlbsd_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tlbsd_pkg::status_t out_status,
  input tlbsd_pkg::slot_t   out_slot,
  input tlbsd_pkg::addr_t   out_inv_addr,
  input logic               out_send_ipi,
  input logic               out_last
);
  import tlbsd_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot)
      && $stable(out_inv_addr) && $stable(out_send_ipi) && $stable(out_last))
    else $error("result changed while stalled");

  // every result other than an invalidate closes its request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_INVAL |-> out_last && out_inv_addr == '0)
    else $error("non-invalidate result not last or carries an address");

  // only a post raises the interrupt request
  a_ipi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_send_ipi == (out_status == ST_POSTED)))
    else $error("interrupt flag does not match posted status");

  // drop ready once a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request");

endmodule

bind tlb_shootdown_mailbox_table tlbsd_chk u_tlbsd_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_slot     (out_slot),
  .out_inv_addr (out_inv_addr),
  .out_send_ipi (out_send_ipi),
  .out_last     (out_last)
);
